// ----- hw/rtl/sorls_pkg.sv -----
// Shared types, widths, reset values and helper functions of the steer offset estimator.
// Used by sorls_mul, sorls_div and steer_offset_rls_estimator_unit; depends on nothing.
package sorls_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAG_W     = 31;
  localparam int DATA_W    = 32;

  localparam int MUL_B_W   = DATA_W;
  localparam int MUL_A_W   = 2 * MAG_W - FRAC_BITS;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  localparam int DIV_N_W   = 2 * MAG_W;
  localparam int DIV_D_W   = 2 * MAG_W + 1 - FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam int WIDE_W    = PROD_W - FRAC_BITS + 2;
  localparam int LAM_W     = 17;
  localparam int CFG_IDX_W = 3;

  localparam int S_TDATA_W = 3 * DATA_W;
  localparam int M_FIELD_W = DATA_W + MAG_W + DATA_W + 2;
  localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

  localparam logic [PROD_W-1:0] T_CAP    = PROD_W'(1) << (2 * MAG_W);
  localparam logic [MAG_W-1:0]  PREP_LIM = MAG_W'((1 << FRAC_BITS) / 1000);
  localparam logic [MAG_W-1:0]  U31_MAX  = {MAG_W{1'b1}};

  localparam logic [MAG_W-1:0]  WHEEL_BASE_RST = 31'd182845;
  localparam logic [LAM_W-1:0]  FORGET_RST     = 17'd65470;
  localparam logic [MAG_W-1:0]  MIN_SPEED_RST  = 31'd327680;
  localparam logic [MAG_W-1:0]  MAX_STEER_RST  = 31'd3277;
  localparam logic [MAG_W-1:0]  INIT_COV_RST   = 31'd65536000;
  localparam logic [DATA_W-1:0] INIT_OFS_RST   = 32'd0;
  localparam logic [MAG_W-1:0]  WARN_LIM_RST   = 31'd572;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_BASE,
    CFG_FORGETTING_FACTOR,
    CFG_MIN_VALID_SPEED,
    CFG_MAX_VALID_STEER,
    CFG_INITIAL_COVARIANCE,
    CFG_INITIAL_OFFSET,
    CFG_WARN_OFFSET_LIMIT
  } cfg_e;

  typedef enum logic [1:0] {
    DIAG_PREPARING,
    DIAG_WARN,
    DIAG_OK
  } diag_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHI,
    ST_PHI2,
    ST_T,
    ST_PNEW,
    ST_PK,
    ST_KM,
    ST_E,
    ST_OFS,
    ST_DONE
  } state_e;

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  function automatic logic [WIDE_W-1:0] sext32(input logic [DATA_W-1:0] v);
    return {{(WIDE_W - DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic [WIDE_W-1:0] v);
    if (!v[WIDE_W-1] && (|v[WIDE_W-2:DATA_W-1])) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v[WIDE_W-1] && !(&v[WIDE_W-2:DATA_W-1])) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

  function automatic logic [MAG_W-1:0] sat31(input logic [DIV_N_W-1:0] v);
    return (|v[DIV_N_W-1:MAG_W]) ? U31_MAX : v[MAG_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/steer_offset_rls_estimator_unit.sv -----
// Steer offset estimator top level: scalar recursive least squares with forgetting.
// Depends on sorls_pkg, sorls_mul and sorls_div.
//
// One item in, one result out. An item that triggers an update runs a sequence of
// three divisions on the bit-serial divider and five multiplications on the
// bit-serial multiplier, one after the other; an item without an update goes
// straight to the output stage. The
// input is taken only while the sequencer is idle; the result sits in an output
// register until taken and a new item is not accepted before it has been loaded.
// Covariance, offset and configuration reset to their documented values; writing
// initial_covariance also reloads the covariance at once.
module steer_offset_rls_estimator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sorls_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sorls_pkg::DATA_W-1:0]      cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // speed [31:0], yaw_rate [63:32], steer_angle [95:64]
  input  logic [sorls_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // motion_valid [0]
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // offset_estimate [31:0], covariance_out [62:32], offset_error [94:63],
  // diag_status [96:95], zero fill [103:97]
  output logic [sorls_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // updated [0]
  output logic [0:0]                        m_axis_tuser
);

  localparam int F  = sorls_pkg::FRAC_BITS;
  localparam int DW = sorls_pkg::DATA_W;
  localparam int MW = sorls_pkg::MAG_W;

  sorls_pkg::state_e state_q, state_d;

  logic [MW-1:0]               wb_q, minv_q, maxs_q, icov_q, warn_q;
  logic [sorls_pkg::LAM_W-1:0] ff_q;
  logic [DW-1:0]               iofs_q;
  logic [MW-1:0]               cov_q;
  logic [DW-1:0]               ofs_q;

  logic                         neg_q, upd_q, sneg_q, eneg_q;
  logic [DW-1:0]                yaw_q, steer_q;
  logic [MW-1:0]                phim_q, pnew_q, km_q;
  logic [sorls_pkg::DIV_D_W-1:0] d_q;

  logic                    m_valid_q, m_upd_q;
  logic [DW-1:0]           out_ofs_q, out_err_q;
  logic [MW-1:0]           out_cov_q;
  sorls_pkg::diag_e        out_diag_q;

  logic                          mul_start, mul_done;
  logic [sorls_pkg::MUL_A_W-1:0] mul_a;
  logic [sorls_pkg::MUL_B_W-1:0] mul_b;
  logic [sorls_pkg::PROD_W-1:0]  mul_prod;
  logic                          div_start, div_done;
  logic [sorls_pkg::DIV_N_W-1:0] div_num, div_quot;
  logic [sorls_pkg::DIV_D_W-1:0] div_den;

  logic                 accept, upd_in;
  logic [DW-1:0]        in_spd, in_yaw, in_steer, in_spd_mag;
  logic [MW-1:0]        quot_sat;
  logic [sorls_pkg::LAM_W-1:0]   lam;
  logic [sorls_pkg::PROD_W-1:0]  t_cap;
  logic [sorls_pkg::DIV_D_W-1:0] d_new;
  logic                 m_neg;
  logic [sorls_pkg::WIDE_W-1:0] m_mag, m_sgn;
  logic [DW-1:0]        s_val, e_val, ofs_new, err_val;
  sorls_pkg::diag_e     diag;

  logic ld_in, ld_phim, ld_d, ld_pnew, ld_km, ld_s, ld_e, commit, ld_out;

  sorls_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  sorls_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign in_spd     = s_axis_tdata[DW-1:0];
  assign in_yaw     = s_axis_tdata[2*DW-1:DW];
  assign in_steer   = s_axis_tdata[3*DW-1:2*DW];
  assign in_spd_mag = sorls_pkg::mag32(in_spd);

  assign s_axis_tready = (state_q == sorls_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign upd_in        = s_axis_tuser[0]
                      && (in_spd_mag >= {1'b0, minv_q})
                      && (sorls_pkg::mag32(in_steer) <= {1'b0, maxs_q})
                      && (wb_q != '0);

  assign quot_sat = sorls_pkg::sat31(div_quot);
  assign lam      = (ff_q == '0) ? sorls_pkg::LAM_W'(1) : ff_q;
  assign t_cap    = (mul_prod > sorls_pkg::T_CAP) ? sorls_pkg::T_CAP : mul_prod;
  assign d_new    = sorls_pkg::DIV_D_W'(lam)
                  + sorls_pkg::DIV_D_W'(t_cap >> F);

  assign m_neg   = (state_q == sorls_pkg::ST_E) ? (neg_q ^ sneg_q) : (neg_q ^ eneg_q);
  assign m_mag   = sorls_pkg::WIDE_W'(mul_prod >> F);
  assign m_sgn   = m_neg ? (~m_mag + sorls_pkg::WIDE_W'(1)) : m_mag;
  assign s_val   = sorls_pkg::sat32(sorls_pkg::sext32(steer_q) + sorls_pkg::sext32(ofs_q));
  assign e_val   = sorls_pkg::sat32(sorls_pkg::sext32(yaw_q) - m_sgn);
  assign ofs_new = sorls_pkg::sat32(sorls_pkg::sext32(ofs_q) + m_sgn);
  assign err_val = sorls_pkg::sat32(sorls_pkg::sext32(ofs_q) - sorls_pkg::sext32(iofs_q));

  always_comb begin
    if (cov_q > sorls_pkg::PREP_LIM) begin
      diag = sorls_pkg::DIAG_PREPARING;
    end else if (sorls_pkg::mag32(ofs_q) > {1'b0, warn_q}) begin
      diag = sorls_pkg::DIAG_WARN;
    end else begin
      diag = sorls_pkg::DIAG_OK;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    ld_in     = 1'b0;
    ld_phim   = 1'b0;
    ld_d      = 1'b0;
    ld_pnew   = 1'b0;
    ld_km     = 1'b0;
    ld_s      = 1'b0;
    ld_e      = 1'b0;
    commit    = 1'b0;
    ld_out    = 1'b0;
    case (state_q)
      sorls_pkg::ST_IDLE: begin
        if (accept) begin
          ld_in = 1'b1;
          if (upd_in) begin
            div_start = 1'b1;
            div_num   = sorls_pkg::DIV_N_W'({in_spd_mag, {F{1'b0}}});
            div_den   = sorls_pkg::DIV_D_W'(wb_q);
            state_d   = sorls_pkg::ST_PHI;
          end else begin
            state_d = sorls_pkg::ST_DONE;
          end
        end
      end
      sorls_pkg::ST_PHI: begin
        if (div_done) begin
          ld_phim   = 1'b1;
          mul_start = 1'b1;
          mul_a     = sorls_pkg::MUL_A_W'(quot_sat);
          mul_b     = sorls_pkg::MUL_B_W'(quot_sat);
          state_d   = sorls_pkg::ST_PHI2;
        end
      end
      sorls_pkg::ST_PHI2: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = sorls_pkg::MUL_A_W'(mul_prod >> F);
          mul_b     = sorls_pkg::MUL_B_W'(cov_q);
          state_d   = sorls_pkg::ST_T;
        end
      end
      sorls_pkg::ST_T: begin
        if (mul_done) begin
          ld_d      = 1'b1;
          div_start = 1'b1;
          div_num   = sorls_pkg::DIV_N_W'({cov_q, {F{1'b0}}});
          div_den   = d_new;
          state_d   = sorls_pkg::ST_PNEW;
        end
      end
      sorls_pkg::ST_PNEW: begin
        if (div_done) begin
          ld_pnew   = 1'b1;
          mul_start = 1'b1;
          mul_a     = sorls_pkg::MUL_A_W'(cov_q);
          mul_b     = sorls_pkg::MUL_B_W'(phim_q);
          state_d   = sorls_pkg::ST_PK;
        end
      end
      sorls_pkg::ST_PK: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = mul_prod[sorls_pkg::DIV_N_W-1:0];
          div_den   = d_q;
          state_d   = sorls_pkg::ST_KM;
        end
      end
      sorls_pkg::ST_KM: begin
        if (div_done) begin
          ld_km     = 1'b1;
          ld_s      = 1'b1;
          mul_start = 1'b1;
          mul_a     = sorls_pkg::MUL_A_W'(phim_q);
          mul_b     = sorls_pkg::mag32(s_val);
          state_d   = sorls_pkg::ST_E;
        end
      end
      sorls_pkg::ST_E: begin
        if (mul_done) begin
          ld_e      = 1'b1;
          mul_start = 1'b1;
          mul_a     = sorls_pkg::MUL_A_W'(km_q);
          mul_b     = sorls_pkg::mag32(e_val);
          state_d   = sorls_pkg::ST_OFS;
        end
      end
      sorls_pkg::ST_OFS: begin
        if (mul_done) begin
          commit  = 1'b1;
          state_d = sorls_pkg::ST_DONE;
        end
      end
      sorls_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          ld_out  = 1'b1;
          state_d = sorls_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sorls_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sorls_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ld_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q   <= sorls_pkg::WHEEL_BASE_RST;
      ff_q   <= sorls_pkg::FORGET_RST;
      minv_q <= sorls_pkg::MIN_SPEED_RST;
      maxs_q <= sorls_pkg::MAX_STEER_RST;
      icov_q <= sorls_pkg::INIT_COV_RST;
      iofs_q <= sorls_pkg::INIT_OFS_RST;
      warn_q <= sorls_pkg::WARN_LIM_RST;
      cov_q  <= sorls_pkg::INIT_COV_RST;
      ofs_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sorls_pkg::CFG_WHEEL_BASE:        wb_q   <= cfg_data_i[MW-1:0];
          sorls_pkg::CFG_FORGETTING_FACTOR: ff_q   <= cfg_data_i[sorls_pkg::LAM_W-1:0];
          sorls_pkg::CFG_MIN_VALID_SPEED:   minv_q <= cfg_data_i[MW-1:0];
          sorls_pkg::CFG_MAX_VALID_STEER:   maxs_q <= cfg_data_i[MW-1:0];
          sorls_pkg::CFG_INITIAL_OFFSET:    iofs_q <= cfg_data_i;
          sorls_pkg::CFG_WARN_OFFSET_LIMIT: warn_q <= cfg_data_i[MW-1:0];
          sorls_pkg::CFG_INITIAL_COVARIANCE: begin
            icov_q <= cfg_data_i[MW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cfg_we_i && (cfg_idx_i == sorls_pkg::CFG_INITIAL_COVARIANCE)) begin
        cov_q <= cfg_data_i[MW-1:0];
      end else if (commit) begin
        cov_q <= pnew_q;
      end
      if (commit) begin
        ofs_q <= ofs_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_in) begin
      neg_q   <= in_spd[DW-1];
      upd_q   <= upd_in;
      yaw_q   <= in_yaw;
      steer_q <= in_steer;
    end
    if (ld_phim) begin
      phim_q <= quot_sat;
    end
    if (ld_d) begin
      d_q <= d_new;
    end
    if (ld_pnew) begin
      pnew_q <= quot_sat;
    end
    if (ld_km) begin
      km_q <= quot_sat;
    end
    if (ld_s) begin
      sneg_q <= s_val[DW-1];
    end
    if (ld_e) begin
      eneg_q <= e_val[DW-1];
    end
    if (ld_out) begin
      m_upd_q    <= upd_q;
      out_ofs_q  <= ofs_q;
      out_cov_q  <= cov_q;
      out_err_q  <= err_val;
      out_diag_q <= diag;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_upd_q;
  assign m_axis_tdata  = sorls_pkg::M_TDATA_W'({out_diag_q, out_err_q, out_cov_q, out_ofs_q});

  // icov_q holds the register value; the live covariance is loaded alongside it
  logic unused_icov;
  assign unused_icov = ^icov_q;

endmodule

// ----- hw/rtl/sorls_mul.sv -----
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on sorls_pkg for operand and product widths.
module sorls_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [sorls_pkg::MUL_A_W-1:0]   a_i,
  input  logic [sorls_pkg::MUL_B_W-1:0]   b_i,
  output logic                            done_o,
  output logic [sorls_pkg::PROD_W-1:0]    prod_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [sorls_pkg::MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [sorls_pkg::PROD_W-1:0]    prod_q, prod_d;
  logic [sorls_pkg::MUL_A_W-1:0]   a_q, a_d;
  logic [sorls_pkg::MUL_A_W:0]     sum;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    a_d    = a_q;
    sum    = {1'b0, prod_q[sorls_pkg::PROD_W-1:sorls_pkg::MUL_B_W]}
           + {1'b0, (prod_q[0] ? a_q : '0)};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = sorls_pkg::MUL_CNT_W'(sorls_pkg::MUL_B_W);
      prod_d = sorls_pkg::PROD_W'(b_i);
      a_d    = a_i;
    end else if (busy_q) begin
      prod_d = {sum, prod_q[sorls_pkg::MUL_B_W-1:1]};
      cnt_d  = cnt_q - sorls_pkg::MUL_CNT_W'(1);
      if (cnt_q == sorls_pkg::MUL_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    a_q    <= a_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ----- hw/rtl/sorls_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sorls_pkg for dividend and divisor widths.
module sorls_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [sorls_pkg::DIV_N_W-1:0]   num_i,
  input  logic [sorls_pkg::DIV_D_W-1:0]   den_i,
  output logic                            done_o,
  output logic [sorls_pkg::DIV_N_W-1:0]   quot_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [sorls_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [sorls_pkg::DIV_N_W-1:0]   num_q, num_d;
  logic [sorls_pkg::DIV_D_W-1:0]   rem_q, rem_d;
  logic [sorls_pkg::DIV_D_W-1:0]   den_q, den_d;
  logic [sorls_pkg::DIV_D_W:0]     trial;
  logic [sorls_pkg::DIV_D_W:0]     diff;
  logic                            ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, num_q[sorls_pkg::DIV_N_W-1]};
    diff   = trial - {1'b0, den_q};
    ge     = (trial >= {1'b0, den_q});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = sorls_pkg::DIV_CNT_W'(sorls_pkg::DIV_N_W);
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[sorls_pkg::DIV_D_W-1:0] : trial[sorls_pkg::DIV_D_W-1:0];
      num_d = {num_q[sorls_pkg::DIV_N_W-2:0], ge};
      cnt_d = cnt_q - sorls_pkg::DIV_CNT_W'(1);
      if (cnt_q == sorls_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for steer_offset_rls_estimator_unit.
// Drives a directed table and random items; predicts in SV the results not in the table.
// Depends on sorls_pkg and the estimator RTL only.
`timescale 1ns / 1ps

module tb_top;
  import sorls_pkg::*;

  localparam int N_PHASES = 6;
  localparam int RAND_ITEMS = 1030;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint unsigned PRODUCT_CAP = 64'h4000_0000_0000_0000;
  localparam longint unsigned MAG31_MAX = 64'h7fff_ffff;

  typedef struct packed {
    logic        upd;
    logic [31:0] ofs;
    logic [30:0] cov;
    logic [31:0] err;
    diag_e       diag;
  } est_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [31:0]           val;
    logic                  mv;
    logic [31:0]           spd;
    logic [31:0]           yaw;
    logic [31:0]           str;
    logic                  typed;
    est_result_t           want;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [DATA_W-1:0]      cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  steer_offset_rls_estimator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  logic [30:0]     cfg_wheel_base = WHEEL_BASE_RST;
  logic [16:0]     cfg_lambda = FORGET_RST;
  logic [30:0]     cfg_min_speed = MIN_SPEED_RST;
  logic [30:0]     cfg_max_steer = MAX_STEER_RST;
  logic [30:0]     cfg_init_cov = INIT_COV_RST;
  logic [31:0]     cfg_init_ofs = INIT_OFS_RST;
  logic [30:0]     cfg_warn_lim = WARN_LIM_RST;
  longint unsigned cov_st = 64'(INIT_COV_RST);
  longint          ofs_st = 0;

  est_result_t pending_est_q[$];
  int          n_mismatch = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  logic        calm = 1'b0;

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint clip32(longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  function automatic longint mul_q(longint a, longint b);
    longint unsigned p;
    p = (mag64(a) * mag64(b)) >> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    case (idx)
      CFG_WHEEL_BASE:         cfg_wheel_base = v[30:0];
      CFG_FORGETTING_FACTOR:  cfg_lambda = v[16:0];
      CFG_MIN_VALID_SPEED:    cfg_min_speed = v[30:0];
      CFG_MAX_VALID_STEER:    cfg_max_steer = v[30:0];
      CFG_INITIAL_COVARIANCE: begin
        cfg_init_cov = v[30:0];
        cov_st = 64'(v[30:0]);
      end
      CFG_INITIAL_OFFSET:     cfg_init_ofs = v;
      CFG_WARN_OFFSET_LIMIT:  cfg_warn_lim = v[30:0];
      default: ;
    endcase
  endfunction

  function automatic est_result_t step_estimate(logic mv, logic [31:0] spd, logic [31:0] yaw,
                                                logic [31:0] str);
    longint          s_spd, s_yaw, s_str, phi, k, s, e, err;
    longint unsigned phim, lam, p, phi2, t, d, pnew, km;
    logic            upd;
    est_result_t     r;
    s_spd = longint'($signed(spd));
    s_yaw = longint'($signed(yaw));
    s_str = longint'($signed(str));
    upd = mv && mag64(s_spd) >= 64'(cfg_min_speed) && mag64(s_str) <= 64'(cfg_max_steer)
          && cfg_wheel_base != 0;
    if (upd) begin
      phim = (mag64(s_spd) << FRAC_BITS) / 64'(cfg_wheel_base);
      lam = (cfg_lambda != 0) ? 64'(cfg_lambda) : 64'd1;
      p = cov_st;
      if (phim > MAG31_MAX) phim = MAG31_MAX;
      phi2 = (phim * phim) >> FRAC_BITS;
      if (phi2 != 0 && p > PRODUCT_CAP / phi2) t = PRODUCT_CAP;
      else t = phi2 * p;
      d = lam + (t >> FRAC_BITS);
      pnew = (p << FRAC_BITS) / d;
      if (pnew > MAG31_MAX) pnew = MAG31_MAX;
      km = (p * phim) / d;
      if (km > MAG31_MAX) km = MAG31_MAX;
      phi = spd[31] ? -longint'(phim) : longint'(phim);
      k = spd[31] ? -longint'(km) : longint'(km);
      s = clip32(s_str + ofs_st);
      e = clip32(s_yaw - mul_q(phi, s));
      ofs_st = clip32(ofs_st + mul_q(k, e));
      cov_st = pnew;
    end
    err = clip32(ofs_st - longint'($signed(cfg_init_ofs)));
    r.upd = upd;
    r.ofs = ofs_st[31:0];
    r.cov = cov_st[30:0];
    r.err = err[31:0];
    if (cov_st * 64'd1000 > (64'd1 << FRAC_BITS)) r.diag = DIAG_PREPARING;
    else if (mag64(ofs_st) > 64'(cfg_warn_lim)) r.diag = DIAG_WARN;
    else r.diag = DIAG_OK;
    return r;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic dir_row_t row_item(logic mv, logic [31:0] spd, logic [31:0] yaw,
                                        logic [31:0] str);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.mv = mv;
    r.spd = spd;
    r.yaw = yaw;
    r.str = str;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = v;
    return r;
  endfunction

  function automatic dir_row_t with_want(dir_row_t r, est_result_t w);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  task automatic report(string msg);
    n_mismatch++;
    if (n_mismatch <= 30) $display("mismatch: %s", msg);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_est_q.size() != 0 || !s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    apply_cfg(idx, v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(logic mv, logic [31:0] spd, logic [31:0] yaw, logic [31:0] str,
                           logic typed, est_result_t want);
    est_result_t pred;
    int          gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mv;
    s_axis_tdata <= {str, yaw, spd};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = step_estimate(mv, spd, yaw, str);
    pending_est_q.push_back(typed ? want : pred);
    gap = calm ? 0 : draw_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : rx_pace
    int nxt;
    if (calm) begin
      m_axis_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      nxt = draw_gap();
      m_axis_tready <= (nxt == 0);
      stall_left <= (nxt == 0) ? 0 : nxt - 1;
    end
  end

  always @(posedge clk_i) begin : result_check
    est_result_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_est_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        w = pending_est_q.pop_front();
        if (m_axis_tuser[0] !== w.upd)
          report($sformatf("updated got %b want %b", m_axis_tuser[0], w.upd));
        if (m_axis_tdata[31:0] !== w.ofs)
          report($sformatf("offset_estimate got %h want %h", m_axis_tdata[31:0], w.ofs));
        if (m_axis_tdata[62:32] !== w.cov)
          report($sformatf("covariance_out got %h want %h", m_axis_tdata[62:32], w.cov));
        if (m_axis_tdata[94:63] !== w.err)
          report($sformatf("offset_error got %h want %h", m_axis_tdata[94:63], w.err));
        if (m_axis_tdata[96:95] !== w.diag)
          report($sformatf("diag_status got %0d want %0d", m_axis_tdata[96:95], w.diag));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t        dir_rows[$];
    logic [31:0]     pv[7];
    logic [31:0]     spd, yaw, str;
    logic            mv;
    longint          m;
    longint unsigned st;

    dir_rows = '{
      with_want(row_item(1'b0, 32'h0, 32'h0, 32'h0),
                est_result_t'{1'b0, 32'h0, INIT_COV_RST, 32'h0, DIAG_PREPARING}),
      row_cfg(CFG_INITIAL_OFFSET, 32'h8000_0000),
      with_want(row_item(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff),
                est_result_t'{1'b0, 32'h0, INIT_COV_RST, 32'h7fff_ffff, DIAG_PREPARING}),
      row_cfg(CFG_INITIAL_OFFSET, 32'h7fff_ffff),
      with_want(row_item(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h5555_5555),
                est_result_t'{1'b0, 32'h0, INIT_COV_RST, 32'h8000_0001, DIAG_PREPARING}),
      row_cfg(CFG_INITIAL_COVARIANCE, 32'h0),
      row_cfg(CFG_WARN_OFFSET_LIMIT, 32'h0),
      with_want(row_item(1'b0, 32'haaaa_aaaa, 32'h0000_ffff, 32'hffff_0000),
                est_result_t'{1'b0, 32'h0, 31'h0, 32'h8000_0001, DIAG_OK}),
      row_cfg(CFG_INITIAL_COVARIANCE, 32'(INIT_COV_RST)),
      row_cfg(CFG_WARN_OFFSET_LIMIT, 32'(WARN_LIM_RST)),
      row_cfg(CFG_INITIAL_OFFSET, INIT_OFS_RST),
      row_item(1'b1, 32'd327680, 32'd1000, 32'd3277),
      row_item(1'b1, 32'hfffb_0000, 32'hffff_fc18, 32'hffff_f333),
      row_item(1'b1, 32'd327679, 32'd1000, 32'd0),
      row_item(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0),
      row_item(1'b1, 32'h8000_0000, 32'h8000_0000, 32'd0),
      row_item(1'b1, 32'd655360, 32'd500, 32'd3278),
      row_item(1'b0, 32'd655360, 32'd500, 32'd0),
      row_item(1'b1, 32'd655360, 32'd500, 32'h8000_0000),
      row_cfg(CFG_WHEEL_BASE, 32'h0),
      row_item(1'b1, 32'd655360, 32'd100, 32'd0),
      row_cfg(CFG_WHEEL_BASE, 32'h1),
      row_item(1'b1, 32'h7fff_ffff, 32'd100, 32'd10),
      row_cfg(CFG_WHEEL_BASE, 32'hffff_ffff),
      row_item(1'b1, 32'h8000_0000, 32'd5, 32'd0),
      row_cfg(CFG_WHEEL_BASE, 32'(WHEEL_BASE_RST)),
      row_cfg(CFG_FORGETTING_FACTOR, 32'h0),
      row_item(1'b1, 32'd1310720, 32'd2000, 32'd100),
      row_cfg(CFG_FORGETTING_FACTOR, 32'h0001_ffff),
      row_item(1'b1, 32'd1310720, 32'hffff_f830, 32'hffff_ff9c),
      row_cfg(CFG_FORGETTING_FACTOR, 32'h0001_0000),
      row_item(1'b1, 32'hffec_0000, 32'd2000, 32'd100),
      row_cfg(CFG_MIN_VALID_SPEED, 32'h0),
      row_cfg(CFG_MAX_VALID_STEER, 32'h7fff_ffff),
      row_item(1'b1, 32'd0, 32'd123, 32'h7fff_ffff),
      row_item(1'b1, 32'd0, 32'd123, 32'h8000_0000),
      row_cfg(CFG_MIN_VALID_SPEED, 32'h7fff_ffff),
      row_cfg(CFG_MAX_VALID_STEER, 32'h0),
      row_item(1'b1, 32'h8000_0000, 32'd7, 32'd0),
      row_item(1'b1, 32'h7fff_fffe, 32'd7, 32'd0),
      row_cfg(CFG_IDX_UNUSED, 32'hffff_ffff),
      row_cfg(CFG_FORGETTING_FACTOR, 32'(FORGET_RST)),
      row_cfg(CFG_MIN_VALID_SPEED, 32'(MIN_SPEED_RST)),
      row_cfg(CFG_MAX_VALID_STEER, 32'(MAX_STEER_RST))
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_item(dir_rows[i].mv, dir_rows[i].spd, dir_rows[i].yaw, dir_rows[i].str,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          pv[CFG_WHEEL_BASE] = 32'(WHEEL_BASE_RST);
          pv[CFG_FORGETTING_FACTOR] = 32'(FORGET_RST);
          pv[CFG_MIN_VALID_SPEED] = 32'(MIN_SPEED_RST);
          pv[CFG_MAX_VALID_STEER] = 32'(MAX_STEER_RST);
          pv[CFG_INITIAL_COVARIANCE] = 32'(INIT_COV_RST);
          pv[CFG_INITIAL_OFFSET] = INIT_OFS_RST;
          pv[CFG_WARN_OFFSET_LIMIT] = 32'(WARN_LIM_RST);
        end
        1: begin
          pv[CFG_WHEEL_BASE] = 32'h1;
          pv[CFG_FORGETTING_FACTOR] = 32'h0001_0000;
          pv[CFG_MIN_VALID_SPEED] = 32'h0;
          pv[CFG_MAX_VALID_STEER] = 32'h7fff_ffff;
          pv[CFG_INITIAL_COVARIANCE] = 32'h7fff_ffff;
          pv[CFG_INITIAL_OFFSET] = 32'h8000_0000;
          pv[CFG_WARN_OFFSET_LIMIT] = 32'h0;
        end
        2: begin
          pv[CFG_WHEEL_BASE] = 32'h7fff_ffff;
          pv[CFG_FORGETTING_FACTOR] = 32'h1;
          pv[CFG_MIN_VALID_SPEED] = 32'h7fff_ffff;
          pv[CFG_MAX_VALID_STEER] = 32'h0;
          pv[CFG_INITIAL_COVARIANCE] = 32'h0;
          pv[CFG_INITIAL_OFFSET] = 32'h7fff_ffff;
          pv[CFG_WARN_OFFSET_LIMIT] = 32'h7fff_ffff;
        end
        default: begin
          pv[CFG_WHEEL_BASE] = {1'($urandom_range(0, 1)), 31'($urandom_range(40000, 400000))};
          pv[CFG_FORGETTING_FACTOR] = ($urandom & 32'hfffe_0000) |
              (($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                           : $urandom_range(60000, 65536));
          pv[CFG_MIN_VALID_SPEED] = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 655360))};
          pv[CFG_MAX_VALID_STEER] = {1'($urandom_range(0, 1)),
              31'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h7fff_ffff)
                                              : $urandom_range(0, 65536))};
          pv[CFG_INITIAL_COVARIANCE] = {1'($urandom_range(0, 1)),
              31'($urandom_range(0, 1) ? $urandom_range(0, 1000)
                                       : $urandom_range(0, 32'h7fff_ffff))};
          pv[CFG_INITIAL_OFFSET] = $urandom;
          pv[CFG_WARN_OFFSET_LIMIT] = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 131072))};
        end
      endcase
      for (int i = CFG_WHEEL_BASE; i <= CFG_WARN_OFFSET_LIMIT; i++) begin
        write_reg(i[CFG_IDX_W-1:0], pv[i]);
      end

      for (int n = 0; n < RAND_ITEMS / N_PHASES; n++) begin
        if (calm ? ($urandom_range(0, 14) == 0) : ($urandom_range(0, 59) == 0)) calm <= !calm;
        if ($urandom_range(0, 3) != 0) begin
          mv = 1'b1;
          m = longint'(cfg_min_speed) + longint'($urandom_range(0, 1310720));
          if (m > S32_HI) m = S32_HI + longint'($urandom_range(0, 1));
          spd = $urandom_range(0, 1) ? 32'(-m) : 32'(m);
          st = (cfg_max_steer == 0) ? 0 : longint'($urandom_range(0, cfg_max_steer));
          str = $urandom_range(0, 1) ? 32'(-longint'(st)) : 32'(st);
          yaw = $urandom_range(0, 1) ? $urandom
                                     : 32'(longint'($urandom_range(0, 524288)) - 262144);
        end else begin
          mv = 1'($urandom_range(0, 1));
          spd = $urandom;
          yaw = $urandom;
          str = $urandom;
        end
        send_item(mv, spd, yaw, str, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_est_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sorls_pkg.sv
hw/rtl/sorls_mul.sv
hw/rtl/sorls_div.sv
hw/rtl/steer_offset_rls_estimator_unit.sv
tb/tb_top.sv
